// ===== hdl/stepper_tray_positioner_top_macros.svh =====
// ----------------------------------------------------------------------------
// Stepper tray positioner assertion macros
// Shared concurrent assertion shorthands for the positioner RTL.
// ----------------------------------------------------------------------------
`ifndef STEPPER_TRAY_POSITIONER_TOP_MACROS_SVH
`define STEPPER_TRAY_POSITIONER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define STP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stp assertion failed");

// Next-cycle implication, disabled while in reset.
`define STP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stp assertion failed");

`endif

// ===== hdl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper tray positioner package
// Types, register indexes and the coil pattern table.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEPS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QTR_STEPS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_QTR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_HALF  = 3'd6;

  localparam logic [1:0] TRAY_BLACK = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_DWELL  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] min_delay_ms;
    logic [7:0] accel_start_delay_ms;
    logic [7:0] decel_end_delay_ms;
    logic [7:0] half_turn_steps;
    logic [7:0] quarter_turn_steps;
    logic [7:0] dwell_quarter_ms;
    logic [7:0] dwell_half_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         tray_now;
    logic [1:0]         coil_phase;
    phase_t             move_phase;
    logic               move_clockwise;
    logic [7:0]         step_delay;
    logic [COUNT_W-1:0] wait_left;
    logic [COUNT_W-1:0] cruise_left;
    logic               long_dwell;
    logic [5:0]         drive_bits;
  } state_t;

  typedef struct packed {
    logic [1:0] tray_position;
    logic       rejected;
    logic       done_res;
    logic       busy_res;
    logic       step_pulse;
    logic [5:0] coil_pattern;
  } result_t;

  // Dual-phase coil patterns, one per coil phase.
  function automatic logic [5:0] coil_pattern_of(input logic [1:0] ph);
    logic [5:0] pat;
    case (ph)
      2'd0:    pat = 6'b110110;
      2'd1:    pat = 6'b101110;
      2'd2:    pat = 6'b101101;
      default: pat = 6'b110101;
    endcase
    return pat;
  endfunction

  // Place of a tray on the clockwise ring: aluminium, white, steel, black.
  function automatic logic [1:0] ring_pos(input logic [1:0] tray);
    return {tray[0], tray[1]};
  endfunction

endpackage

// ===== hdl/stp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Stepper tray positioner configuration registers
// Holds the ramp, step count and dwell settings written over the cfg port.
// ----------------------------------------------------------------------------
module stp_cfg_regs
  import stp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_delay_ms         <= 8'd6;
      cfg_r.accel_start_delay_ms <= 8'd12;
      cfg_r.decel_end_delay_ms   <= 8'd12;
      cfg_r.half_turn_steps      <= 8'd100;
      cfg_r.quarter_turn_steps   <= 8'd50;
      cfg_r.dwell_quarter_ms     <= 8'd20;
      cfg_r.dwell_half_ms        <= 8'd40;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MIN_DELAY:   cfg_r.min_delay_ms         <= wr_data;
        CFG_ACCEL_START: cfg_r.accel_start_delay_ms <= wr_data;
        CFG_DECEL_END:   cfg_r.decel_end_delay_ms   <= wr_data;
        CFG_HALF_STEPS:  cfg_r.half_turn_steps      <= wr_data;
        CFG_QTR_STEPS:   cfg_r.quarter_turn_steps   <= wr_data;
        CFG_DWELL_QTR:   cfg_r.dwell_quarter_ms     <= wr_data;
        CFG_DWELL_HALF:  cfg_r.dwell_half_ms        <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/stp_step_logic.sv =====
// ----------------------------------------------------------------------------
// Stepper tray positioner step logic
// Next-state and result for one tick or sort request.
// ----------------------------------------------------------------------------
module stp_step_logic
  import stp_pkg::*;
(
  input  cfg_t       cfg,
  input  state_t     st,
  input  logic       req_type,
  input  logic [1:0] material,
  output state_t     st_nxt,
  output result_t    res
);

  // Walk of the ramp sequence when the current wait runs out.
  logic             acc_go;
  logic             at_cruise;
  logic             cru_go;
  logic             at_decel;
  logic [7:0]       dec_delay;
  logic             dec_go;
  logic [7:0]       dwell_sel;
  logic [1:0]       step_phase;

  // Move setup for a request.
  logic [1:0]       diff;
  logic [7:0]       total;
  logic [7:0]       up;
  logic [7:0]       down;
  logic [8:0]       ramps;

  assign acc_go     = (st.move_phase == PH_ACCEL) && (st.step_delay > cfg.min_delay_ms);
  assign at_cruise  = (st.move_phase == PH_CRUISE) || ((st.move_phase == PH_ACCEL) && !acc_go);
  assign cru_go     = at_cruise && (st.cruise_left != '0);
  assign at_decel   = (st.move_phase == PH_DECEL) || (at_cruise && !cru_go);
  assign dec_delay  = (st.move_phase == PH_DECEL) ? st.step_delay : cfg.min_delay_ms;
  assign dec_go     = at_decel && (dec_delay < cfg.decel_end_delay_ms);
  assign dwell_sel  = st.long_dwell ? cfg.dwell_half_ms : cfg.dwell_quarter_ms;
  assign step_phase = st.move_clockwise ? st.coil_phase + 2'd1 : st.coil_phase - 2'd1;

  assign diff  = ring_pos(material) - ring_pos(st.tray_now);
  assign total = (diff == 2'd2) ? cfg.half_turn_steps : cfg.quarter_turn_steps;
  assign up    = (cfg.accel_start_delay_ms > cfg.min_delay_ms)
               ? cfg.accel_start_delay_ms - cfg.min_delay_ms : 8'd0;
  assign down  = (cfg.decel_end_delay_ms > cfg.min_delay_ms)
               ? cfg.decel_end_delay_ms - cfg.min_delay_ms : 8'd0;
  assign ramps = {1'b0, up} + {1'b0, down};

  always_comb begin
    logic [COUNT_W-1:0] wait_dec;
    logic               pulse;
    logic               done;
    logic               rej;
    logic [7:0]         period;

    st_nxt   = st;
    pulse    = 1'b0;
    done     = 1'b0;
    rej      = 1'b0;
    period   = 8'd0;
    wait_dec = (st.wait_left != '0) ? st.wait_left - 1'b1 : '0;

    if (req_type) begin
      if (st.move_phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        if (diff == 2'd0) begin
          st_nxt.long_dwell = 1'b1;
          st_nxt.move_phase = PH_DWELL;
          st_nxt.wait_left  = COUNT_W'(cfg.dwell_half_ms);
        end else begin
          st_nxt.cruise_left    = ({1'b0, total} > ramps)
                                ? COUNT_W'(total - ramps[7:0]) : '0;
          st_nxt.long_dwell     = (diff == 2'd2);
          st_nxt.move_clockwise = (diff != 2'd3);
          st_nxt.step_delay     = cfg.accel_start_delay_ms;
          st_nxt.wait_left      = '0;
          st_nxt.move_phase     = PH_ACCEL;
        end
        st_nxt.tray_now = material;
      end
    end else if (st.move_phase != PH_IDLE) begin
      st_nxt.wait_left = wait_dec;
      if (wait_dec == '0) begin
        if (acc_go) begin
          pulse             = 1'b1;
          period            = st.step_delay;
          st_nxt.step_delay = st.step_delay - 8'd1;
        end else if (cru_go) begin
          pulse              = 1'b1;
          period             = cfg.min_delay_ms;
          st_nxt.cruise_left = st.cruise_left - 1'b1;
          st_nxt.move_phase  = PH_CRUISE;
        end else if (dec_go) begin
          pulse             = 1'b1;
          period            = dec_delay;
          st_nxt.step_delay = dec_delay + 8'd1;
          st_nxt.move_phase = PH_DECEL;
        end else if (at_decel) begin
          st_nxt.step_delay = dec_delay;
          if (dwell_sel != 8'd0) begin
            st_nxt.move_phase = PH_DWELL;
            st_nxt.wait_left  = COUNT_W'(dwell_sel);
          end else begin
            st_nxt.move_phase = PH_IDLE;
            done              = 1'b1;
          end
        end else begin
          // dwell ran out
          st_nxt.move_phase = PH_IDLE;
          done              = 1'b1;
        end
        if (pulse) begin
          st_nxt.coil_phase = step_phase;
          st_nxt.drive_bits = coil_pattern_of(step_phase);
          st_nxt.wait_left  = COUNT_W'(period);
        end
      end
    end

    res.coil_pattern  = st_nxt.drive_bits;
    res.step_pulse    = pulse;
    res.busy_res      = (st_nxt.move_phase != PH_IDLE);
    res.done_res      = done;
    res.rejected      = rej;
    res.tray_position = st_nxt.tray_now;
  end

endmodule

// ===== hdl/stepper_tray_positioner_top.sv =====
// ----------------------------------------------------------------------------
// Stepper tray positioner top level
// Tick and sort request stream in, coil drive and status stream out.
// ----------------------------------------------------------------------------
// Path: a result reaches out_tdata through the input register, then the
//   result register.
// Throughput: one transaction per cycle while out_tready is held high; the single-pass
//   step logic between the input register and the result register sets that figure.
// Reset: rst_n is synchronous, active low; it empties both registers, parks
//   the tray at black with coils off and loads the default settings.
// ----------------------------------------------------------------------------
`include "stepper_tray_positioner_top_macros.svh"

module stepper_tray_positioner_top
  import stp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [1:0] material, [7:2] zero
  input  logic [0:0]           in_tuser,   // [0] req_type (0 tick, 1 sort request)
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [5:0] coil_pattern, [6] step_pulse,
                                           // [7] busy_res, [8] done_res,
                                           // [9] rejected, [11:10] tray_position,
                                           // [15:12] zero
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_t       cfg;

  // Input register stage.
  logic       s1_valid_r;
  logic       s1_req_r;
  logic [1:0] s1_mat_r;

  // Positioner state and result register.
  state_t     st_r;
  state_t     st_nxt;
  result_t    res_nxt;
  result_t    res_r;
  logic       out_valid_r;
  logic       out_load;

  // The user must write settings only while the block is idle; the block does not enforce it, so no hold-off here.
  assign cfg_ready = 1'b1;

  stp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The state is updated exactly when an item moves into the result register,
  // so items are applied in order and a stall freezes everything.
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r <= in_tuser[0];
      s1_mat_r <= in_tdata[1:0];
    end
  end

  stp_step_logic u_step (
    .cfg      (cfg),
    .st       (st_r),
    .req_type (s1_req_r),
    .material (s1_mat_r),
    .st_nxt   (st_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.tray_now       <= TRAY_BLACK;
      st_r.coil_phase     <= 2'd0;
      st_r.move_phase     <= PH_IDLE;
      st_r.move_clockwise <= 1'b0;
      st_r.step_delay     <= 8'd0;
      st_r.wait_left      <= '0;
      st_r.cruise_left    <= '0;
      st_r.long_dwell     <= 1'b0;
      st_r.drive_bits     <= 6'd0;
    end else if (out_load) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r};

  // A step leaves the motor in a moving phase.
  `STP_ASSERT_IMP(a_pulse_busy, clk, rst_n, out_valid_r && res_r.step_pulse, res_r.busy_res)
  // Finishing a move returns the block to idle.
  `STP_ASSERT_IMP(a_done_idle, clk, rst_n, out_valid_r && res_r.done_res, !res_r.busy_res)
  // No wait is pending while idle.
  `STP_ASSERT_IMP(a_idle_wait, clk, rst_n, st_r.move_phase == PH_IDLE, st_r.wait_left == '0)
  // A rejected request leaves the tray where it is.
  `STP_ASSERT_NXT(a_rej_tray, clk, rst_n, out_load && res_nxt.rejected, $stable(st_r.tray_now))

endmodule
